// File: sv/assert_macros.svh
// Assertion macros shared by the contrast stretch RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/rcs_pkg.sv
// Types and constants shared by the contrast stretch modules
package rcs_pkg;

  localparam int CH_W        = 8;
  localparam int PIX_W       = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int DIV_CNT_W   = 3;

  localparam logic OP_SCAN  = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  typedef struct packed {
    logic             op;
    logic             last;
    logic [PIX_W-1:0] pixel;
    logic [CH_W-1:0]  ch_r;
    logic [CH_W-1:0]  ch_g;
    logic [CH_W-1:0]  ch_b;
    logic [CH_W-1:0]  ch_min;
    logic [CH_W-1:0]  ch_max;
  } rcs_item_t;

  typedef struct packed {
    logic busy;
    logic fill;
  } rcs_back_stat_t;

endpackage

// File: sv/rcs_front.sv
// Front end: request handshake and per-pixel channel classification
module rcs_front #(
  parameter int COLOR_LEVELS = 256
) (
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_opcode,
  input  logic [31:0]             in_pixel_in,
  input  logic                    in_last_in,
  input  logic                    q_full,
  output logic                    q_push,
  output rcs_pkg::rcs_item_t      item
);
  import rcs_pkg::*;

  localparam logic [CH_W-1:0] TOP = CH_W'(COLOR_LEVELS - 1);

  function automatic logic [CH_W-1:0] sat(input logic [CH_W-1:0] c);
    sat = (c > TOP) ? TOP : c;
  endfunction

  logic [CH_W-1:0] r_s, g_s, b_s;
  logic [CH_W-1:0] rg_max, rg_min;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign b_s = sat(in_pixel_in[7:0]);
  assign g_s = sat(in_pixel_in[15:8]);
  assign r_s = sat(in_pixel_in[23:16]);

  assign rg_max = (r_s > g_s) ? r_s : g_s;
  assign rg_min = (r_s < g_s) ? r_s : g_s;

  always_comb begin
    item.op     = in_opcode;
    item.last   = in_last_in;
    item.pixel  = in_pixel_in;
    item.ch_r   = r_s;
    item.ch_g   = g_s;
    item.ch_b   = b_s;
    item.ch_max = (b_s > rg_max) ? b_s : rg_max;
    item.ch_min = (b_s < rg_min) ? b_s : rg_min;
  end

endmodule

// File: sv/rcs_queue.sv
// Short request queue between front and back end
module rcs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rcs_pkg::rcs_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output rcs_pkg::rcs_item_t pop_item
);
  import rcs_pkg::*;

  rcs_item_t           mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  assign full     = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_item = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// File: sv/rcs_back.sv
// Back end: range tracking, table build and pixel mapping
module rcs_back #(
  parameter int COLOR_LEVELS = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_enable,
  input  logic                   q_valid,
  input  rcs_pkg::rcs_item_t     q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            out_pixel_out,
  output logic                   out_last_out,
  output rcs_pkg::rcs_back_stat_t stat
);
  import rcs_pkg::*;

  localparam int LVL_W = (COLOR_LEVELS > 2) ? $clog2(COLOR_LEVELS) : 1;
  localparam logic [CH_W-1:0]  TOP      = CH_W'(COLOR_LEVELS - 1);
  localparam logic [LVL_W-1:0] LAST_IDX = LVL_W'(COLOR_LEVELS - 1);

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_DIV  = 3'b010,
    ST_FILL = 3'b100
  } state_t;

  state_t state_r;

  logic [CH_W-1:0] run_max_r, run_min_r, frame_max_r, frame_min_r;
  logic [CH_W-1:0] scan_max, scan_min, span;

  // shared divider: (COLOR_LEVELS - 1) / span, one quotient bit per cycle
  logic [CH_W-1:0]      div_rem_r, div_quo_r, div_rem_nxt, div_quo_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [CH_W:0]        div_trial;
  logic                 div_ge;

  // fill walk: quotient and remainder of (v - min) * (COLOR_LEVELS - 1) / span
  logic [LVL_W-1:0] idx_r;
  logic [CH_W-1:0]  acc_q_r, acc_r_r, acc_q_nxt, acc_r_nxt;
  logic [CH_W:0]    acc_sum;
  logic [CH_W-1:0]  idx_ext, fill_val;
  logic             below, above, flat;

  logic [CH_W-1:0] tab_r [COLOR_LEVELS];
  logic [CH_W-1:0] tab_g [COLOR_LEVELS];
  logic [CH_W-1:0] tab_b [COLOR_LEVELS];
  logic [CH_W-1:0] rd_r_r, rd_g_r, rd_b_r;

  logic             res_valid_r, res_last_r, res_byp_r;
  logic [PIX_W-1:0] res_pix_r;

  logic out_free, pop_scan, pop_apply, filling;

  assign out_free  = !res_valid_r || !out_stall;
  assign q_pop     = (state_r == ST_RUN) && q_valid && ((q_item.op == OP_SCAN) || out_free);
  assign pop_scan  = q_pop && (q_item.op == OP_SCAN);
  assign pop_apply = q_pop && (q_item.op == OP_APPLY);
  assign filling   = (state_r == ST_FILL);

  assign scan_max = (q_item.ch_max > run_max_r) ? q_item.ch_max : run_max_r;
  assign scan_min = (q_item.ch_min < run_min_r) ? q_item.ch_min : run_min_r;
  assign span     = frame_max_r - frame_min_r;

  always_comb begin
    div_trial   = {div_rem_r, TOP[div_cnt_r]};
    div_ge      = (div_trial >= {1'b0, span});
    div_rem_nxt = div_ge ? CH_W'(div_trial - {1'b0, span}) : div_trial[CH_W-1:0];
    div_quo_nxt = div_quo_r | (CH_W'(div_ge) << div_cnt_r);
  end

  always_comb begin
    idx_ext  = CH_W'(idx_r);
    below    = (idx_ext < frame_min_r);
    above    = (idx_ext > frame_max_r);
    flat     = (frame_max_r <= frame_min_r);
    fill_val = (flat || below) ? '0 : (above ? TOP : acc_q_r);
    acc_sum  = {1'b0, acc_r_r} + {1'b0, div_rem_r};
    // remainder stays below twice the span: one compare and subtract
    if (acc_sum >= {1'b0, span}) begin
      acc_r_nxt = CH_W'(acc_sum - {1'b0, span});
      acc_q_nxt = acc_q_r + div_quo_r + 1'b1;
    end else begin
      acc_r_nxt = acc_sum[CH_W-1:0];
      acc_q_nxt = acc_q_r + div_quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (filling) begin
      tab_r[idx_r] <= fill_val;
      tab_g[idx_r] <= fill_val;
      tab_b[idx_r] <= fill_val;
    end
    if (pop_apply) begin
      rd_r_r <= tab_r[q_item.ch_r[LVL_W-1:0]];
      rd_g_r <= tab_g[q_item.ch_g[LVL_W-1:0]];
      rd_b_r <= tab_b[q_item.ch_b[LVL_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop_apply) begin
      res_pix_r  <= q_item.pixel;
      res_last_r <= q_item.last;
      res_byp_r  <= !cfg_enable || ((frame_max_r == TOP) && (frame_min_r == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      run_max_r   <= '0;
      run_min_r   <= TOP;
      frame_max_r <= '0;
      frame_min_r <= TOP;
      div_rem_r   <= '0;
      div_quo_r   <= '0;
      div_cnt_r   <= '0;
      idx_r       <= '0;
      acc_q_r     <= '0;
      acc_r_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (pop_apply) begin
        res_valid_r <= 1'b1;
      end else if (res_valid_r && !out_stall) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        ST_RUN: begin
          if (pop_scan) begin
            if (q_item.last) begin
              // latch range, restart accumulators and start the build
              frame_max_r <= scan_max;
              frame_min_r <= scan_min;
              run_max_r   <= '0;
              run_min_r   <= TOP;
              div_rem_r   <= '0;
              div_quo_r   <= '0;
              div_cnt_r   <= DIV_CNT_W'(CH_W - 1);
              state_r     <= ST_DIV;
            end else begin
              run_max_r <= scan_max;
              run_min_r <= scan_min;
            end
          end
        end
        ST_DIV: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= div_quo_nxt;
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_cnt_r == '0) begin
            idx_r   <= '0;
            acc_q_r <= '0;
            acc_r_r <= '0;
            state_r <= ST_FILL;
          end
        end
        ST_FILL: begin
          if (!below && !above) begin
            acc_q_r <= acc_q_nxt;
            acc_r_r <= acc_r_nxt;
          end
          idx_r <= idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            state_r <= ST_RUN;
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

  assign out_valid     = res_valid_r;
  assign out_last_out  = res_last_r;
  assign out_pixel_out = res_byp_r ? res_pix_r : {8'h00, rd_r_r, rd_g_r, rd_b_r};

  assign stat.busy = (state_r != ST_RUN);
  assign stat.fill = filling;

endmodule

// File: sv/rgb_contrast_stretch_top.sv
// Top level of the min/max contrast stretch over RGB888 pixels
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  input   | in_opcode, in_pixel_in, in_last_in      | in_valid / in_stall
//  result  | out_pixel_out, out_last_out             | out_valid / out_stall
//  config  | cfg_wr_data (enable)                    | cfg_wr_en, no wait
//
//  The back end pops scan and apply requests only outside a table build; an apply result is
//  registered at the edge that pops its request from the four-entry queue.
//  A last scan request starts a table build of eight divider steps, then one table entry
//  per cycle; the queue keeps taking requests.
//  Reset is synchronous; the table holds no defined value until the first build.
//  out_stall holds the result register; in_stall rises only when the queue is full.
module rgb_contrast_stretch_top #(
  parameter int COLOR_LEVELS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [31:0] in_pixel_in,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel_out,
  output logic        out_last_out
);
  import rcs_pkg::*;

  `include "assert_macros.svh"

  logic           cfg_enable_r;
  logic           q_full, q_push, q_pop, q_valid;
  rcs_item_t      front_item, q_item;
  rcs_back_stat_t back_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_enable_r <= 1'b1;
    end else if (cfg_wr_en) begin
      cfg_enable_r <= cfg_wr_data;
    end
  end

  rcs_front #(
    .COLOR_LEVELS(COLOR_LEVELS)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_pixel_in (in_pixel_in),
    .in_last_in  (in_last_in),
    .q_full      (q_full),
    .q_push      (q_push),
    .item        (front_item)
  );

  rcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_item)
  );

  rcs_back #(
    .COLOR_LEVELS(COLOR_LEVELS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_enable    (cfg_enable_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_last_out  (out_last_out),
    .stat          (back_stat)
  );

  `ASSERT_IMPLIES(a_no_pop_while_building, clk, rst_n, back_stat.busy, !q_pop)
  `ASSERT_IMPLIES(a_pop_only_when_queued, clk, rst_n, q_pop, q_valid)
  `ASSERT_NEXT(a_fill_returns_to_run, clk, rst_n, back_stat.fill, back_stat.fill || !back_stat.busy)
  `ASSERT_NEXT(a_accepted_is_queued, clk, rst_n, in_valid && !in_stall, q_valid)

endmodule
